// ===== hw/rtl/mfc_pkg.sv =====
// Shared types and constants for the motorized fader controller.
// No dependencies; used by every module of the block.
package mfc_pkg;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_BYTE   = 2'd1;
  localparam logic [1:0] ACT_TOUCH  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL  = 3'd6;

  localparam logic [15:0] UPPER_RST    = 16'd16383;
  localparam logic [15:0] LOWER_RST    = 16'd0;
  localparam logic [11:0] DEADBAND_RST = 12'd150;
  localparam logic [3:0]  SPEED_RST    = 4'd4;
  localparam logic [11:0] STEP_RST     = 12'd60;
  localparam logic [11:0] MARGIN_RST   = 12'd20;
  localparam logic [3:0]  CHANNEL_RST  = 4'd0;

  localparam logic [15:0] TARGET_RST   = 16'd11800;
  localparam logic [3:0]  SPEED_MAX    = 4'd10;
  localparam logic [3:0]  BEND_NIBBLE  = 4'hE;
  localparam logic [7:0]  STATUS_NOTE  = 8'h90;
  localparam logic [7:0]  STATUS_BEND  = 8'hE0;
  localparam logic [6:0]  NOTE_BASE    = 7'h18;
  localparam logic [6:0]  VEL_ON       = 7'h7F;
  localparam logic [6:0]  VEL_OFF      = 7'h00;
  localparam logic [15:0] REPORT_TOP   = 16'd16383;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int LVL_W      = 3;

  typedef struct packed {
    logic [15:0] upper_limit;
    logic [15:0] lower_limit;
    logic [11:0] deadband;
    logic [3:0]  move_speed;
    logic [11:0] report_step;
    logic [11:0] end_margin;
    logic [3:0]  midi_channel;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       touched;
  } item_t;

  typedef struct packed {
    logic [3:0] up_drive;
    logic [3:0] down_drive;
    logic       msg_valid;
    logic [7:0] msg_status;
    logic [6:0] msg_data1;
    logic [6:0] msg_data2;
    logic       last;
  } result_t;

endpackage

// ===== hw/rtl/mfc_step.sv =====
// Controller state and single-step update: averaging, pitch-bend parser, motor
// and touch/report logic. Depends on mfc_pkg.
module mfc_step #(
  parameter int AVG_LEN = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  mfc_pkg::item_t           item,
  input  logic [33+$clog2(AVG_LEN)-1:0] inc,
  input  mfc_pkg::cfg_t            cfg,
  output mfc_pkg::result_t         res0,
  output mfc_pkg::result_t         res1,
  output logic                     two
);

  localparam int LG    = $clog2(AVG_LEN);
  localparam int SH    = 16 + 2 * LG;
  localparam int ACC_W = 33 + 2 * LG;
  localparam int CNT_W = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;

  typedef enum logic [1:0] {M_BRAKE, M_UP, M_DOWN} mode_t;
  typedef enum logic [1:0] {P_STATUS, P_LOW, P_HIGH} phase_t;

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      pos_r, pos_nxt;
  logic [15:0]      tgt_r, tgt_nxt;
  logic [13:0]      pend_tgt_r, pend_tgt_nxt;
  logic             pend_v_r, pend_v_nxt;
  phase_t           phase_r, phase_nxt;
  logic [6:0]       low_r, low_nxt;
  mode_t            mode_r, mode_nxt;
  logic             touch_r, touch_nxt;
  logic             touch_prev_r, touch_prev_nxt;
  logic [15:0]      lastrep_r, lastrep_nxt;

  logic [ACC_W-1:0] sum;
  logic [16:0]      pos17, tgt17, db17, lr17, st17, em17, up17, lo17;
  logic             stop, note_v, rep_v;
  logic [15:0]      rep;
  logic [3:0]       spd;
  mfc_pkg::result_t note_r, bend_r, empty_r;

  always_comb begin
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    tgt_nxt        = tgt_r;
    pend_tgt_nxt   = pend_tgt_r;
    pend_v_nxt     = pend_v_r;
    phase_nxt      = phase_r;
    low_nxt        = low_r;
    mode_nxt       = mode_r;
    touch_nxt      = touch_r;
    touch_prev_nxt = touch_prev_r;
    lastrep_nxt    = lastrep_r;
    sum            = acc_r + ACC_W'(inc);
    stop           = 1'b0;
    rep_v          = 1'b0;
    rep            = 16'd0;

    case (item.action)
      mfc_pkg::ACT_SAMPLE: begin
        if (cnt_r == CNT_W'(AVG_LEN - 1)) begin
          pos_nxt = sum[SH +: 16];
          acc_nxt = '0;
          cnt_nxt = '0;
        end else begin
          acc_nxt = sum;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      mfc_pkg::ACT_BYTE: begin
        case (phase_r)
          P_STATUS: begin
            if (item.rx_byte[7:4] == mfc_pkg::BEND_NIBBLE) phase_nxt = P_LOW;
          end
          P_LOW: begin
            low_nxt   = item.rx_byte[6:0];
            phase_nxt = P_HIGH;
          end
          default: begin
            phase_nxt = P_STATUS;
            if (mode_r != M_BRAKE) begin
              pend_tgt_nxt = {item.rx_byte[6:0], low_r};
              pend_v_nxt   = 1'b1;
            end else if (!touch_r) begin
              tgt_nxt = {2'b00, item.rx_byte[6:0], low_r};
            end
          end
        endcase
      end
      mfc_pkg::ACT_TOUCH: begin
        touch_nxt = item.touched;
      end
      default: begin
      end
    endcase

    pos17 = {1'b0, pos_nxt};
    db17  = 17'(cfg.deadband);
    lr17  = {1'b0, lastrep_r};
    st17  = 17'(cfg.report_step);
    em17  = 17'(cfg.end_margin);
    up17  = {1'b0, cfg.upper_limit};
    lo17  = {1'b0, cfg.lower_limit};

    // stop check on a running motor
    tgt17 = {1'b0, tgt_nxt};
    if (mode_r != M_BRAKE) begin
      stop = (mode_r == M_UP) ? (pos17 + db17 >= tgt17) : (pos17 <= tgt17 + db17);
      if (stop) begin
        mode_nxt   = M_BRAKE;
        tgt_nxt    = (pend_v_nxt && !touch_nxt) ? {2'b00, pend_tgt_nxt} : pos_nxt;
        pend_v_nxt = 1'b0;
      end
    end

    // start check on a braked motor
    tgt17 = {1'b0, tgt_nxt};
    if (mode_nxt == M_BRAKE && !touch_nxt) begin
      if (tgt17 > pos17 + db17 && tgt_nxt < cfg.upper_limit) begin
        mode_nxt = M_UP;
      end else if (tgt17 + db17 < pos17 && tgt_nxt > cfg.lower_limit) begin
        mode_nxt = M_DOWN;
      end
    end

    note_v         = touch_nxt != touch_prev_r;
    touch_prev_nxt = touch_nxt;

    if (touch_nxt && (pos17 >= lr17 + st17 || pos17 + st17 <= lr17)) begin
      rep_v       = 1'b1;
      tgt_nxt     = pos_nxt;
      lastrep_nxt = pos_nxt;
      rep         = pos_nxt;
      if (pos17 + em17 >= up17) rep = mfc_pkg::REPORT_TOP;
      if (pos17 <= lo17 + em17) rep = 16'd0;
    end

    spd = (cfg.move_speed > mfc_pkg::SPEED_MAX) ? mfc_pkg::SPEED_MAX : cfg.move_speed;

    empty_r            = '0;
    empty_r.up_drive   = (mode_nxt == M_UP) ? spd : 4'd0;
    empty_r.down_drive = (mode_nxt == M_DOWN) ? spd : 4'd0;

    note_r            = empty_r;
    note_r.msg_valid  = 1'b1;
    note_r.msg_status = mfc_pkg::STATUS_NOTE;
    note_r.msg_data1  = mfc_pkg::NOTE_BASE + 7'(cfg.midi_channel);
    note_r.msg_data2  = touch_nxt ? mfc_pkg::VEL_ON : mfc_pkg::VEL_OFF;

    bend_r            = empty_r;
    bend_r.msg_valid  = 1'b1;
    bend_r.msg_status = mfc_pkg::STATUS_BEND + 8'(cfg.midi_channel);
    bend_r.msg_data1  = rep[6:0];
    bend_r.msg_data2  = rep[13:7];
    bend_r.last       = 1'b1;

    empty_r.last = 1'b1;

    two = note_v && rep_v;
    if (note_v) begin
      res0      = note_r;
      res0.last = !rep_v;
    end else if (rep_v) begin
      res0 = bend_r;
    end else begin
      res0 = empty_r;
    end
    res1 = bend_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r        <= '0;
      cnt_r        <= '0;
      pos_r        <= 16'd0;
      tgt_r        <= mfc_pkg::TARGET_RST;
      pend_tgt_r   <= 14'd0;
      pend_v_r     <= 1'b0;
      phase_r      <= P_STATUS;
      low_r        <= 7'd0;
      mode_r       <= M_BRAKE;
      touch_r      <= 1'b0;
      touch_prev_r <= 1'b0;
      lastrep_r    <= 16'd0;
    end else if (fire) begin
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      pos_r        <= pos_nxt;
      tgt_r        <= tgt_nxt;
      pend_tgt_r   <= pend_tgt_nxt;
      pend_v_r     <= pend_v_nxt;
      phase_r      <= phase_nxt;
      low_r        <= low_nxt;
      mode_r       <= mode_nxt;
      touch_r      <= touch_nxt;
      touch_prev_r <= touch_prev_nxt;
      lastrep_r    <= lastrep_nxt;
    end
  end

endmodule

// ===== hw/rtl/mfc_out_fifo.sv =====
// Four-entry result queue taking up to two results per cycle, one out.
// Depends on mfc_pkg.
module mfc_out_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [1:0]                 push_n,
  input  mfc_pkg::result_t           wr0,
  input  mfc_pkg::result_t           wr1,
  input  logic                       pop,
  output mfc_pkg::result_t           head,
  output logic [mfc_pkg::LVL_W-1:0]  level
);

  mfc_pkg::result_t                mem_r [mfc_pkg::FIFO_DEPTH];
  logic [mfc_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [mfc_pkg::LVL_W-1:0]       level_r;

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= wr0;
    if (push_n == 2'd2) mem_r[wr_ptr_r + mfc_pkg::PTR_W'(1)] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + mfc_pkg::PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + mfc_pkg::PTR_W'(pop);
      level_r  <= level_r + mfc_pkg::LVL_W'(push_n) - mfc_pkg::LVL_W'(pop);
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign level = level_r;

endmodule

// ===== hw/rtl/motorized_fader_controller_unit.sv =====
// Motorized fader controller, top level. Depends on mfc_pkg, mfc_step and
// mfc_out_fifo.
//
// One input transfer is taken per cycle. Each transfer passes an input register
// (where the ADC sample is scaled for the block average) and is then applied to
// the controller state, giving one or two result transfers into a four-entry
// queue whose head drives the output. The sustained rate is one item per cycle
// while each item gives one result and the output is not stalled; an item that
// gives two results (touch edge plus position report) pushes both into the
// queue together, and input stalls only while the queue holds three or more.
// Configuration writes take effect at once and should be made while idle.
module motorized_fader_controller_unit #(
  parameter int AVG_LEN = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_action,
  input  logic [15:0]                     in_adc_sample,
  input  logic [7:0]                      in_rx_byte,
  input  logic                            in_touched,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      out_up_drive,
  output logic [3:0]                      out_down_drive,
  output logic                            out_msg_valid,
  output logic [7:0]                      out_msg_status,
  output logic [6:0]                      out_msg_data1,
  output logic [6:0]                      out_msg_data2,
  output logic                            out_last
);

  localparam int LG    = $clog2(AVG_LEN);
  localparam int SH    = 16 + 2 * LG;
  localparam int MUL_W = 17 + LG;
  localparam int INC_W = 33 + LG;
  localparam logic [MUL_W-1:0] MUL =
    MUL_W'(((64'd1 << SH) + 64'(AVG_LEN) - 64'd1) / 64'(AVG_LEN));

  mfc_pkg::cfg_t      cfg_r;
  logic               s1_v_r;
  mfc_pkg::item_t     s1_item_r;
  logic [INC_W-1:0]   s1_inc_r;
  logic               s1_fire;
  mfc_pkg::result_t   res0, res1, head;
  logic               two;
  logic [1:0]         push_n;
  logic [mfc_pkg::LVL_W-1:0] level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.upper_limit  <= mfc_pkg::UPPER_RST;
      cfg_r.lower_limit  <= mfc_pkg::LOWER_RST;
      cfg_r.deadband     <= mfc_pkg::DEADBAND_RST;
      cfg_r.move_speed   <= mfc_pkg::SPEED_RST;
      cfg_r.report_step  <= mfc_pkg::STEP_RST;
      cfg_r.end_margin   <= mfc_pkg::MARGIN_RST;
      cfg_r.midi_channel <= mfc_pkg::CHANNEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mfc_pkg::CFG_UPPER:    cfg_r.upper_limit  <= cfg_data;
        mfc_pkg::CFG_LOWER:    cfg_r.lower_limit  <= cfg_data;
        mfc_pkg::CFG_DEADBAND: cfg_r.deadband     <= cfg_data[11:0];
        mfc_pkg::CFG_SPEED:    cfg_r.move_speed   <= cfg_data[3:0];
        mfc_pkg::CFG_STEP:     cfg_r.report_step  <= cfg_data[11:0];
        mfc_pkg::CFG_MARGIN:   cfg_r.end_margin   <= cfg_data[11:0];
        mfc_pkg::CFG_CHANNEL:  cfg_r.midi_channel <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // input register; the sample is pre-scaled by the reciprocal of AVG_LEN
  assign s1_fire  = s1_v_r && (level <= mfc_pkg::LVL_W'(2));
  assign in_ready = !s1_v_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.action  <= in_action;
      s1_item_r.rx_byte <= in_rx_byte;
      s1_item_r.touched <= in_touched;
      s1_inc_r          <= INC_W'(in_adc_sample) * INC_W'(MUL);
    end
  end

  mfc_step #(
    .AVG_LEN (AVG_LEN)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .inc   (s1_inc_r),
    .cfg   (cfg_r),
    .res0  (res0),
    .res1  (res1),
    .two   (two)
  );

  assign push_n = s1_fire ? (two ? 2'd2 : 2'd1) : 2'd0;

  mfc_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .wr0    (res0),
    .wr1    (res1),
    .pop    (out_valid && out_ready),
    .head   (head),
    .level  (level)
  );

  assign out_valid      = level != '0;
  assign out_up_drive   = head.up_drive;
  assign out_down_drive = head.down_drive;
  assign out_msg_valid  = head.msg_valid;
  assign out_msg_status = head.msg_status;
  assign out_msg_data1  = head.msg_data1;
  assign out_msg_data2  = head.msg_data2;
  assign out_last       = head.last;

endmodule

// ===== hw/rtl/mfc_checker.sv =====
// Port-level checks for the motorized fader controller, bound to the top level.
// Depends on mfc_pkg and the port names of motorized_fader_controller_unit.
module mfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_up_drive,
  input logic [3:0] out_down_drive,
  input logic       out_msg_valid,
  input logic [7:0] out_msg_status,
  input logic [6:0] out_msg_data1,
  input logic [6:0] out_msg_data2,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_up_drive) &&
    $stable(out_down_drive) && $stable(out_msg_valid) && $stable(out_msg_status) &&
    $stable(out_msg_data1) && $stable(out_msg_data2) && $stable(out_last))
    else $error("result changed while stalled");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_msg_valid |-> out_last)
    else $error("message-free result not final");

  a_one_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_up_drive == 4'd0 || out_down_drive == 4'd0)
    else $error("both windings driven");

  a_duty_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_up_drive <= mfc_pkg::SPEED_MAX && out_down_drive <= mfc_pkg::SPEED_MAX)
    else $error("drive duty over range");

  a_first_note: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_msg_valid && !out_last |-> out_msg_status == mfc_pkg::STATUS_NOTE)
    else $error("non-final result is not a note message");

endmodule

bind motorized_fader_controller_unit mfc_checker u_chk (.*);
